FILE: rtl/clr_pkg.sv
// Shared types and constants for the clipped line rasteriser.
`default_nettype none
package clr_pkg;

	localparam int unsigned MAX_SURFACE = 4096;
	localparam int signed   COORD_LIMIT = 1048576;
	localparam int unsigned CLIP_ROUNDS = 16;

	// outcode bits
	localparam logic [3:0] OC_LEFT   = 4'b0001;
	localparam logic [3:0] OC_RIGHT  = 4'b0010;
	localparam logic [3:0] OC_TOP    = 4'b0100;
	localparam logic [3:0] OC_BOTTOM = 4'b1000;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_STRIDE = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	// command passed from the clipper to the stepper
	typedef struct packed {
		logic        is_load;
		logic        accepted;
		logic [11:0] ax;
		logic [11:0] ay;
		logic [11:0] bx;
		logic [11:0] by;
		logic [15:0] color;
	} cmd_t;

	// one result
	typedef struct packed {
		logic        line_accepted;
		logic        pixel_valid;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [23:0] pixel_address;
		logic [15:0] pixel_color;
		logic        pixel_last;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/clr_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module clr_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [46:0] dividend,
	input  wire logic [23:0] divisor,
	output logic             done,
	output logic [46:0]      quotient
);
	logic [23:0] rem_q;
	logic [46:0] quo_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] trial;
	logic        fits;

	// trial subtraction
	assign trial = {rem_q, quo_q[46]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 24'(trial - {1'b0, den_q}) : trial[23:0];
			quo_q <= {quo_q[45:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: rtl/clr_queue.sv
// Small command queue between the clipper and the stepper.
`default_nettype none
module clr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire clr_pkg::cmd_t wdata,
	output logic               full,
	input  wire logic          pop,
	output logic               nempty,
	output clr_pkg::cmd_t      rdata
);
	localparam int AW = $clog2(clr_pkg::QUEUE_DEPTH);

	clr_pkg::cmd_t mem [clr_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   count_q;

	assign full   = count_q == (AW+1)'(clr_pkg::QUEUE_DEPTH);
	assign nempty = count_q != '0;
	assign rdata  = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + AW'(1);
			if (pop) rptr_q <= rptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + (AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wptr_q] <= wdata;
	end
endmodule
`default_nettype wire

FILE: rtl/clr_front.sv
// Front end: accepts requests, saturates and clips lines, queues commands.
`default_nettype none
module clr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          req_type,
	input  wire logic [31:0]   x_start,
	input  wire logic [31:0]   y_start,
	input  wire logic [31:0]   x_end,
	input  wire logic [31:0]   y_end,
	input  wire logic [15:0]   pen_color,
	input  wire logic [12:0]   surface_width,
	input  wire logic [12:0]   surface_height,
	input  wire logic [12:0]   row_stride,
	output logic               q_push,
	output clr_pkg::cmd_t      q_wdata,
	input  wire logic          q_full
);
	typedef enum logic [2:0] {F_IDLE, F_EVAL, F_MUL, F_DIV, F_WAIT, F_PUSH} fstate_t;

	fstate_t state_q;
	logic signed [23:0] ax_q, ay_q, bx_q, by_q;
	logic [15:0] color_q;
	logic        ok_q;
	logic [4:0]  round_q;
	logic        acc_q;
	logic signed [23:0] ma_q, mb_q, den_q, base_q, fix_q;
	logic        isx_q, use_a_q;
	logic signed [47:0] prod_q;

	logic [3:0] ca, cb, outc;
	logic signed [23:0] dx, dy, xmax, ymax, wx, hy;
	logic signed [23:0] s_den, s_ma, s_mb, s_base, s_fix;
	logic        s_isx;
	logic        surf_ok, accept, div_done;
	logic [46:0] quot;
	logic [46:0] num_mag;
	logic [23:0] den_mag;
	logic signed [23:0] qs, newv;

	function automatic logic signed [23:0] sat(input logic [31:0] raw);
		logic signed [31:0] v;
		v = $signed(raw);
		if (v < -clr_pkg::COORD_LIMIT) return 24'(-clr_pkg::COORD_LIMIT);
		else if (v > clr_pkg::COORD_LIMIT) return 24'(clr_pkg::COORD_LIMIT);
		else return v[23:0];
	endfunction

	function automatic logic [3:0] region(input logic signed [23:0] x,
		input logic signed [23:0] y, input logic signed [23:0] w,
		input logic signed [23:0] h);
		logic [3:0] c;
		c = '0;
		if (x < 0) c = c | clr_pkg::OC_LEFT;
		else if (x >= w) c = c | clr_pkg::OC_RIGHT;
		if (y < 0) c = c | clr_pkg::OC_TOP;
		else if (y >= h) c = c | clr_pkg::OC_BOTTOM;
		return c;
	endfunction

	// surface check and accept
	assign surf_ok = surface_width != '0 && surface_height != '0 &&
		surface_width <= 13'(clr_pkg::MAX_SURFACE) &&
		surface_height <= 13'(clr_pkg::MAX_SURFACE) &&
		row_stride >= surface_width && row_stride <= 13'(clr_pkg::MAX_SURFACE);
	assign in_ready = state_q == F_IDLE && !q_full;
	assign accept   = in_valid && in_ready;

	// outcodes and edge selection
	assign wx   = $signed({11'd0, surface_width});
	assign hy   = $signed({11'd0, surface_height});
	assign xmax = wx - 24'sd1;
	assign ymax = hy - 24'sd1;
	assign ca   = region(ax_q, ay_q, wx, hy);
	assign cb   = region(bx_q, by_q, wx, hy);
	assign outc = (ca != '0) ? ca : cb;
	assign dx   = bx_q - ax_q;
	assign dy   = by_q - ay_q;

	always_comb begin
		s_isx  = 1'b1;
		s_den  = dy;
		s_ma   = dx;
		s_mb   = -ay_q;
		s_base = ax_q;
		s_fix  = '0;
		if ((outc & clr_pkg::OC_TOP) != '0) begin
			s_mb = -ay_q;
		end else if ((outc & clr_pkg::OC_BOTTOM) != '0) begin
			s_mb  = ymax - ay_q;
			s_fix = ymax;
		end else if ((outc & clr_pkg::OC_RIGHT) != '0) begin
			s_isx  = 1'b0;
			s_den  = dx;
			s_ma   = dy;
			s_mb   = xmax - ax_q;
			s_base = ay_q;
			s_fix  = xmax;
		end else begin
			s_isx  = 1'b0;
			s_den  = dx;
			s_ma   = dy;
			s_mb   = -ax_q;
			s_base = ay_q;
		end
	end

	// divider on magnitudes, sign restored afterwards
	assign num_mag = prod_q[47] ? 47'(-prod_q) : prod_q[46:0];
	assign den_mag = den_q[23] ? 24'(-den_q) : den_q;

	clr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == F_DIV),
		.dividend (num_mag),
		.divisor  (den_mag),
		.done     (div_done),
		.quotient (quot)
	);

	assign qs   = (prod_q[47] ^ den_q[23]) ? -$signed(quot[23:0]) : $signed(quot[23:0]);
	assign newv = base_q + qs;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			round_q <= '0;
			acc_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && req_type == clr_pkg::REQ_LOAD) begin
						state_q <= F_EVAL;
						round_q <= '0;
					end
				end
				F_EVAL: begin
					if (!ok_q || round_q == 5'(clr_pkg::CLIP_ROUNDS)) begin
						acc_q   <= 1'b0;
						state_q <= F_PUSH;
					end else if ((ca | cb) == '0) begin
						acc_q   <= 1'b1;
						state_q <= F_PUSH;
					end else if ((ca & cb) != '0 || s_den == '0) begin
						acc_q   <= 1'b0;
						state_q <= F_PUSH;
					end else begin
						state_q <= F_MUL;
					end
				end
				F_MUL:  state_q <= F_DIV;
				F_DIV:  state_q <= F_WAIT;
				F_WAIT: begin
					if (div_done) begin
						round_q <= round_q + 5'd1;
						state_q <= F_EVAL;
					end
				end
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && req_type == clr_pkg::REQ_LOAD) begin
			ax_q    <= sat(x_start);
			ay_q    <= sat(y_start);
			bx_q    <= sat(x_end);
			by_q    <= sat(y_end);
			color_q <= pen_color;
			ok_q    <= surf_ok;
		end
		if (state_q == F_EVAL) begin
			ma_q    <= s_ma;
			mb_q    <= s_mb;
			den_q   <= s_den;
			base_q  <= s_base;
			fix_q   <= s_fix;
			isx_q   <= s_isx;
			use_a_q <= ca != '0;
		end
		if (state_q == F_MUL) prod_q <= ma_q * mb_q;
		if (state_q == F_WAIT && div_done) begin
			if (use_a_q) begin
				ax_q <= isx_q ? newv : fix_q;
				ay_q <= isx_q ? fix_q : newv;
			end else begin
				bx_q <= isx_q ? newv : fix_q;
				by_q <= isx_q ? fix_q : newv;
			end
		end
	end

	// queue write
	always_comb begin
		q_push           = 1'b0;
		q_wdata.is_load  = 1'b1;
		q_wdata.accepted = acc_q;
		q_wdata.ax       = ax_q[11:0];
		q_wdata.ay       = ay_q[11:0];
		q_wdata.bx       = bx_q[11:0];
		q_wdata.by       = by_q[11:0];
		q_wdata.color    = color_q;
		if (state_q == F_PUSH) begin
			q_push = !q_full;
		end else if (accept && req_type == clr_pkg::REQ_STEP) begin
			q_push           = 1'b1;
			q_wdata.is_load  = 1'b0;
			q_wdata.accepted = 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/clr_back.sv
// Back end: Bresenham stepper with registered result.
`default_nettype none
module clr_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_nempty,
	input  wire clr_pkg::cmd_t q_rdata,
	output logic               q_pop,
	input  wire logic [12:0]   row_stride,
	output logic               out_valid,
	input  wire logic          out_ready,
	output clr_pkg::res_t      res
);
	logic        active_q;
	logic [11:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, span_x_q;
	logic signed [12:0] nsy_q;
	logic signed [14:0] err_q;
	logic        xb_q, yb_q;
	logic [15:0] color_q;
	logic        ovalid_q;
	clr_pkg::res_t res_q;
	clr_pkg::res_t res_d;

	logic        last, mv_x, mv_y;
	logic signed [15:0] twice;
	logic [11:0] sx;
	logic [11:0] ady;
	logic [24:0] addr;

	assign q_pop = q_nempty && (!ovalid_q || out_ready);

	// step decisions
	assign last  = cur_x_q == tgt_x_q && cur_y_q == tgt_y_q;
	assign twice = {err_q, 1'b0};
	assign mv_x  = twice >= 16'(nsy_q);
	assign mv_y  = twice <= $signed({4'd0, span_x_q});
	assign addr  = cur_y_q * row_stride + {13'd0, cur_x_q};
	assign sx    = (q_rdata.bx >= q_rdata.ax) ? q_rdata.bx - q_rdata.ax : q_rdata.ax - q_rdata.bx;
	assign ady   = (q_rdata.by >= q_rdata.ay) ? q_rdata.by - q_rdata.ay : q_rdata.ay - q_rdata.by;

	// result of the command at the queue head
	always_comb begin
		res_d = '0;
		if (q_rdata.is_load) begin
			res_d.line_accepted = q_rdata.accepted;
		end else if (active_q) begin
			res_d.pixel_valid   = 1'b1;
			res_d.pixel_x       = cur_x_q;
			res_d.pixel_y       = cur_y_q;
			res_d.pixel_address = addr[23:0];
			res_d.pixel_color   = color_q;
			res_d.pixel_last    = last;
		end
	end

	// stepper state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
			res_q    <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			span_x_q <= '0;
			nsy_q    <= '0;
			err_q    <= '0;
			xb_q     <= 1'b0;
			yb_q     <= 1'b0;
			color_q  <= '0;
		end else begin
			if (q_pop) begin
				ovalid_q <= 1'b1;
				res_q    <= res_d;
				if (q_rdata.is_load) begin
					active_q <= q_rdata.accepted;
					if (q_rdata.accepted) begin
						cur_x_q  <= q_rdata.ax;
						cur_y_q  <= q_rdata.ay;
						tgt_x_q  <= q_rdata.bx;
						tgt_y_q  <= q_rdata.by;
						span_x_q <= sx;
						nsy_q    <= -$signed({1'b0, ady});
						err_q    <= $signed({3'd0, sx}) - $signed({3'd0, ady});
						xb_q     <= !(q_rdata.ax < q_rdata.bx);
						yb_q     <= !(q_rdata.ay < q_rdata.by);
						color_q  <= q_rdata.color;
					end
				end else if (active_q) begin
					if (last) begin
						active_q <= 1'b0;
					end else begin
						err_q <= err_q + (mv_x ? 15'(nsy_q) : 15'sd0)
							+ (mv_y ? $signed({3'd0, span_x_q}) : 15'sd0);
						if (mv_x) cur_x_q <= xb_q ? cur_x_q - 12'd1 : cur_x_q + 12'd1;
						if (mv_y) cur_y_q <= yb_q ? cur_y_q - 12'd1 : cur_y_q + 12'd1;
					end
				end
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
	assign res       = res_q;
endmodule
`default_nettype wire

FILE: rtl/clipped_line_rasterizer.sv
// Top level of the clipped line rasteriser: config registers, clipper, queue, stepper.
//
//  channel | direction | handshake           | payload
//  in      | in        | in_valid/in_ready   | req_type, x_start..y_end, pen_color
//  out     | out       | out_valid/out_ready | line_accepted .. pixel_last
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Steps queue as accepted; the stepper gives one result per clock unless stalled.
// A load runs up to 16 clip rounds, each evaluating, multiplying and then waiting
// on the bit-serial divider for one intersection.
// Reset clears all control state and sets the surface to 128 x 128, stride 128.
// A stalled output keeps its result; the four-entry queue lets the clipper run ahead.
`default_nettype none
module clipped_line_rasterizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [31:0] x_start,
	input  wire logic [31:0] y_start,
	input  wire logic [31:0] x_end,
	input  wire logic [31:0] y_end,
	input  wire logic [15:0] pen_color,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             line_accepted,
	output logic             pixel_valid,
	output logic [11:0]      pixel_x,
	output logic [11:0]      pixel_y,
	output logic [23:0]      pixel_address,
	output logic [15:0]      pixel_color,
	output logic             pixel_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);
	logic [12:0] width_q, height_q, stride_q;
	logic          q_push, q_full, q_pop, q_nempty;
	clr_pkg::cmd_t q_wdata, q_rdata;
	clr_pkg::res_t res;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd128;
			height_q <= 13'd128;
			stride_q <= 13'd128;
		end else if (cfg_valid) begin
			case (cfg_index)
				clr_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				clr_pkg::CFG_HEIGHT: height_q <= cfg_data;
				clr_pkg::CFG_STRIDE: stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	clr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.x_start        (x_start),
		.y_start        (y_start),
		.x_end          (x_end),
		.y_end          (y_end),
		.pen_color      (pen_color),
		.surface_width  (width_q),
		.surface_height (height_q),
		.row_stride     (stride_q),
		.q_push         (q_push),
		.q_wdata        (q_wdata),
		.q_full         (q_full)
	);

	clr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.nempty (q_nempty),
		.rdata  (q_rdata)
	);

	clr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nempty   (q_nempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.row_stride (stride_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign line_accepted = res.line_accepted;
	assign pixel_valid   = res.pixel_valid;
	assign pixel_x       = res.pixel_x;
	assign pixel_y       = res.pixel_y;
	assign pixel_address = res.pixel_address;
	assign pixel_color   = res.pixel_color;
	assign pixel_last    = res.pixel_last;
endmodule
`default_nettype wire

FILE: rtl/clr_checker.sv
// Port-level checks for the clipped line rasteriser, bound to the top level.
`default_nettype none
module clr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        line_accepted,
	input wire logic        pixel_valid,
	input wire logic [11:0] pixel_x,
	input wire logic [23:0] pixel_address,
	input wire logic        pixel_last
);
	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// load and pixel results are exclusive
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(line_accepted && pixel_valid))
		else $error("load and pixel flags both set");

	// no pixel means zero pixel_x and pixel_address
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_valid |-> pixel_x == '0 && pixel_address == '0)
		else $error("pixel fields set without a pixel");

	// last mark only on a pixel
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_last |-> pixel_valid)
		else $error("last mark without a pixel");
endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.line_accepted (line_accepted),
	.pixel_valid   (pixel_valid),
	.pixel_x       (pixel_x),
	.pixel_address (pixel_address),
	.pixel_last    (pixel_last)
);
`default_nettype wire
